### sv/sipf_pkg.sv
// Shared types and constants for the scan isolated-point filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sipf_pkg;

    localparam int RANGE_WIDTH     = 16;
    localparam int INTENSITY_WIDTH = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CMP_WIDTH       = (RANGE_WIDTH > CFG_WIDTH) ? RANGE_WIDTH : CFG_WIDTH;

    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

    localparam logic [RANGE_WIDTH-1:0] NO_RETURN = {RANGE_WIDTH{1'b1}};

    localparam logic [CFG_IDX_WIDTH-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_RANGE = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_RANGE = 2'd2;

    localparam logic [CFG_WIDTH-1:0] THRESHOLD_RESET = 16'd100;
    localparam logic [CFG_WIDTH-1:0] MIN_RANGE_RESET = 16'd0;
    localparam logic [CFG_WIDTH-1:0] MAX_RANGE_RESET = 16'd65534;

    // number of samples of the current scan seen so far
    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_FIRST = 2'd1;
    localparam logic [1:0] SEEN_MORE  = 2'd2;

    typedef struct packed {
        logic [RANGE_WIDTH-1:0]     range;
        logic [INTENSITY_WIDTH-1:0] intensity;
        logic                       scan_end;
    } sample_t;

    typedef struct packed {
        logic [RANGE_WIDTH-1:0]     range;
        logic [INTENSITY_WIDTH-1:0] intensity;
        logic                       removed;
        logic                       scan_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

### sv/sipf_core.sv
// Configuration registers, scan state and the neighbor compare of the filter.
// Depends on sipf_pkg.
`timescale 1ns / 1ps
module sipf_core
    import sipf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,
    input  logic                     fire,
    input  sample_t                  smp,
    output push_t                    push
);

    logic [CFG_WIDTH-1:0]       threshold_reg;
    logic [CFG_WIDTH-1:0]       min_range_reg;
    logic [CFG_WIDTH-1:0]       max_range_reg;
    logic [RANGE_WIDTH-1:0]     prior_reg, prior_next;
    logic [RANGE_WIDTH-1:0]     held_range_reg, held_range_next;
    logic [INTENSITY_WIDTH-1:0] held_inten_reg, held_inten_next;
    logic [1:0]                 seen_reg, seen_next;

    logic [RANGE_WIDTH-1:0] diff_prev, diff_next;
    logic                   held_ok, differs_prev, differs_next, remove;
    result_t                judged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            min_range_reg <= MIN_RANGE_RESET;
            max_range_reg <= MAX_RANGE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_MIN_RANGE: min_range_reg <= cfg_data;
                REG_MAX_RANGE: max_range_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        diff_prev = (held_range_reg > prior_reg) ? held_range_reg - prior_reg
                                                 : prior_reg - held_range_reg;
        diff_next = (held_range_reg > smp.range) ? held_range_reg - smp.range
                                                 : smp.range - held_range_reg;
        held_ok = (held_range_reg != NO_RETURN)
               && (CMP_WIDTH'(held_range_reg) >= CMP_WIDTH'(min_range_reg))
               && (CMP_WIDTH'(held_range_reg) <= CMP_WIDTH'(max_range_reg));
        differs_prev = (prior_reg == NO_RETURN)
                    || (CMP_WIDTH'(diff_prev) > CMP_WIDTH'(threshold_reg));
        differs_next = (smp.range == NO_RETURN)
                    || (CMP_WIDTH'(diff_next) > CMP_WIDTH'(threshold_reg));
        remove = held_ok && differs_prev && differs_next && (seen_reg == SEEN_MORE);

        judged.range     = remove ? NO_RETURN : held_range_reg;
        judged.intensity = remove ? '0 : held_inten_reg;
        judged.removed   = remove;
        judged.scan_end  = 1'b0;
    end

    always_comb
    begin
        push.count     = 2'd0;
        push.res0      = judged;
        push.res1      = '{range: smp.range, intensity: smp.intensity,
                           removed: 1'b0, scan_end: 1'b1};
        prior_next      = prior_reg;
        held_range_next = held_range_reg;
        held_inten_next = held_inten_reg;
        seen_next       = seen_reg;

        if (seen_reg == SEEN_NONE)
        begin
            if (smp.scan_end)
            begin
                push.count = 2'd1;
                push.res0  = push.res1;
            end
            else
            begin
                held_range_next = smp.range;
                held_inten_next = smp.intensity;
                seen_next       = SEEN_FIRST;
            end
        end
        else
        begin
            if (smp.scan_end)
            begin
                push.count      = 2'd2;
                prior_next      = '0;
                held_range_next = '0;
                held_inten_next = '0;
                seen_next       = SEEN_NONE;
            end
            else
            begin
                push.count      = 2'd1;
                prior_next      = judged.range;
                held_range_next = smp.range;
                held_inten_next = smp.intensity;
                seen_next       = SEEN_MORE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg      <= '0;
            held_range_reg <= '0;
            held_inten_reg <= '0;
            seen_reg       <= SEEN_NONE;
        end
        else if (fire)
        begin
            prior_reg      <= prior_next;
            held_range_reg <= held_range_next;
            held_inten_reg <= held_inten_next;
            seen_reg       <= seen_next;
        end
    end

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && smp.scan_end |=> seen_reg == SEEN_NONE)
        else $error("scan state not cleared after final sample");

    a_first_not_removed: assert property (@(posedge clk) disable iff (!rst_n)
        fire && seen_reg != SEEN_MORE |-> !(push.count != 2'd0 && push.res0.removed))
        else $error("first sample of a scan removed");

endmodule

### sv/sipf_out_fifo.sv
// Output queue of the filter: takes up to two results per cycle, hands out one per cycle while result_ready is high.
// Depends on sipf_pkg.
`timescale 1ns / 1ps
module sipf_out_fifo
    import sipf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic [1:0] push_n,
    input  result_t res0,
    input  result_t res1,
    output logic    room,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t head
);

    result_t                   mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_inc;
    logic [FIFO_CNT_WIDTH-1:0] count_reg, count_next;
    logic                      pop;

    assign room         = count_reg <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;
    assign wr_ptr_inc   = wr_ptr_reg + FIFO_PTR_WIDTH'(1);
    assign count_next   = count_reg + FIFO_CNT_WIDTH'(push_n) - FIFO_CNT_WIDTH'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_inc] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_WIDTH'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_WIDTH'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_CNT_WIDTH'(push_n) <= FIFO_CNT_WIDTH'(FIFO_DEPTH) - count_reg)
        else $error("output queue overflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd0 && !pop |=> $stable(count_reg) && $stable(rd_ptr_reg))
        else $error("queue count moved without push or pop");

endmodule

### sv/scan_isolated_point_filter.sv
// Top level of the scan isolated-point filter: input register, core, output queue.
// Depends on sipf_pkg, sipf_core, sipf_out_fifo.
//
// Usage:
//   Samples enter on the sample channel (sample_valid/sample_ready) with
//   sample_range, sample_intensity and scan_end. Results leave on the result
//   channel (result_valid/result_ready) with out_range, out_intensity,
//   was_removed and out_scan_end. Each sample is emitted one request late,
//   judged against its filtered predecessor and its raw successor; the final
//   sample of a scan leaves together with its predecessor (two results).
//   An accepted sample waits in the input register until the output queue
//   has room. Throughput: one sample per cycle while the queue has room;
//   the queue drains one result per cycle while result_ready is high.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while the block is idle; the block does not enforce it.
//   Reset: configuration returns to threshold 100, min 0, max 65534, scan
//   state to start of scan, and the queue empties.
//   Stall: while result_ready is low the four-entry queue fills; sample_ready
//   drops while a sample is held and fewer than two entries are free.
`timescale 1ns / 1ps
module scan_isolated_point_filter
    import sipf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic [RANGE_WIDTH-1:0]     sample_range,
    input  logic [INTENSITY_WIDTH-1:0] sample_intensity,
    input  logic                       scan_end,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [RANGE_WIDTH-1:0]     out_range,
    output logic [INTENSITY_WIDTH-1:0] out_intensity,
    output logic                       was_removed,
    output logic                       out_scan_end
);

    sample_t    in_reg;
    logic       in_vld_reg, in_vld_next;
    logic       accept, fire, room;
    logic [1:0] push_n;
    push_t      push;
    result_t    head;

    assign fire         = in_vld_reg && room;
    assign sample_ready = !in_vld_reg || fire;
    assign accept       = sample_valid && sample_ready;
    assign in_vld_next  = accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    assign push_n       = fire ? push.count : 2'd0;

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= '{range: sample_range, intensity: sample_intensity,
                        scan_end: scan_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    sipf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .smp       (in_reg),
        .push      (push)
    );

    sipf_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_n       (push_n),
        .res0         (push.res0),
        .res1         (push.res1),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign out_range     = head.range;
    assign out_intensity = head.intensity;
    assign was_removed   = head.removed;
    assign out_scan_end  = head.scan_end;

endmodule
